[sv/ppba_pkg.sv]
// Types and constants shared by the particle plane bounce advection block.
`timescale 1ns / 1ps
package ppba_pkg;

  localparam int CoordW = 32;
  localparam int HalfW  = 31;
  localparam int PosW   = 50;
  localparam int DeltaW = 48;
  localparam int QuotW  = 48;
  localparam int FracW  = 16;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  localparam logic [2:0] REG_NORMAL_AXIS  = 3'd0;
  localparam logic [2:0] REG_PLANE_OFFSET = 3'd1;
  localparam logic [2:0] REG_CENTER_U     = 3'd2;
  localparam logic [2:0] REG_CENTER_V     = 3'd3;
  localparam logic [2:0] REG_HALF_RANGE_U = 3'd4;
  localparam logic [2:0] REG_HALF_RANGE_V = 3'd5;
  localparam logic [2:0] REG_TIME_STEP    = 3'd6;

  typedef struct packed {
    logic [1:0]        normal_axis;
    logic [CoordW-1:0] plane_offset;
    logic [CoordW-1:0] center_u;
    logic [CoordW-1:0] center_v;
    logic [HalfW-1:0]  half_range_u;
    logic [HalfW-1:0]  half_range_v;
    logic [HalfW-1:0]  time_step;
  } cfg_t;

  // Classified particle handed from the front to the back.
  typedef struct packed {
    logic [2:0][CoordW-1:0] pos;
    logic [2:0][CoordW-1:0] vel;
    logic [1:0]             axis;
    logic                   cand;
    logic [CoordW-1:0]      num_mag;
    logic [CoordW-1:0]      vel_mag;
  } job_t;

endpackage

[sv/ppba_if.sv]
// Particle input and result channel interfaces.
`timescale 1ns / 1ps
interface ppba_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] pos_x;
  logic [31:0] pos_y;
  logic [31:0] pos_z;
  logic [31:0] vel_x;
  logic [31:0] vel_y;
  logic [31:0] vel_z;
  modport source (output valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, input ready);
  modport sink (input valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, output ready);
endinterface

interface ppba_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] new_pos_x;
  logic [31:0] new_pos_y;
  logic [31:0] new_pos_z;
  logic [31:0] new_vel_x;
  logic [31:0] new_vel_y;
  logic [31:0] new_vel_z;
  logic        wall_hit;
  logic        saturated;
  modport source (output valid, new_pos_x, new_pos_y, new_pos_z, new_vel_x, new_vel_y,
                  new_vel_z, wall_hit, saturated, input ready);
  modport sink (input valid, new_pos_x, new_pos_y, new_pos_z, new_vel_x, new_vel_y,
                new_vel_z, wall_hit, saturated, output ready);
endinterface

[sv/particle_plane_bounce_advect_top.sv]
// Top level of the particle plane bounce advection block.
`timescale 1ns / 1ps
// Advects one particle (Q16.16 position and velocity) per transfer on in_ch over
// time_step against one axis-aligned rectangular wall and returns the result on
// out_ch, with wall_hit and saturated flags. Registers must be written through
// cfg_we / cfg_idx / cfg_data only while idle; the block does not enforce this.
// The front classifies each particle and queues it (QUEUE_DEPTH entries); the
// back runs one particle at a time. A particle that may cross the wall passes
// through the restoring divider for the crossing time and a range check, then
// uses the shared 32x32 multiplier for the displacement, the wall hit test, and
// the multiplier again for the final position. A particle that cannot cross
// skips the divider. The divider sets the throughput of crossing particles.
// in_ch.ready falls only when the queue is full. The result register holds a
// finished result while out_ch.ready is low, and the back waits behind it.
// Synchronous reset empties the queue and the result register and loads the
// register defaults (plane_offset 19661, half ranges 1.0, everything else zero).
module particle_plane_bounce_advect_top #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_idx,
  input  logic [31:0] cfg_data,
  ppba_in_if.sink     in_ch,
  ppba_out_if.source  out_ch
);
  import ppba_pkg::*;

  cfg_t cfg;
  job_t job_in;
  job_t job_out;
  logic q_full;
  logic q_empty;
  logic q_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.normal_axis  <= AXIS_X;
      cfg.plane_offset <= 32'd19661;
      cfg.center_u     <= '0;
      cfg.center_v     <= '0;
      cfg.half_range_u <= 31'd65536;
      cfg.half_range_v <= 31'd65536;
      cfg.time_step    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_NORMAL_AXIS:  cfg.normal_axis  <= cfg_data[1:0];
        REG_PLANE_OFFSET: cfg.plane_offset <= cfg_data;
        REG_CENTER_U:     cfg.center_u     <= cfg_data;
        REG_CENTER_V:     cfg.center_v     <= cfg_data;
        REG_HALF_RANGE_U: cfg.half_range_u <= cfg_data[30:0];
        REG_HALF_RANGE_V: cfg.half_range_v <= cfg_data[30:0];
        REG_TIME_STEP:    cfg.time_step    <= cfg_data[30:0];
        default: begin
        end
      endcase
    end
  end

  assign in_ch.ready = !q_full;

  ppba_front u_front (
    .cfg   (cfg),
    .pos_x (in_ch.pos_x),
    .pos_y (in_ch.pos_y),
    .pos_z (in_ch.pos_z),
    .vel_x (in_ch.vel_x),
    .vel_y (in_ch.vel_y),
    .vel_z (in_ch.vel_z),
    .job   (job_in)
  );

  ppba_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (in_ch.valid && !q_full),
    .push_data (job_in),
    .pop       (q_pop),
    .pop_data  (job_out),
    .full      (q_full),
    .empty     (q_empty)
  );

  ppba_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .job       (job_out),
    .job_avail (!q_empty),
    .job_pop   (q_pop),
    .out_ch    (out_ch)
  );

endmodule

[sv/ppba_front.sv]
// Front: accepts a particle and classifies it against the wall plane.
`timescale 1ns / 1ps
module ppba_front (
  input  ppba_pkg::cfg_t cfg,
  input  logic [31:0]    pos_x,
  input  logic [31:0]    pos_y,
  input  logic [31:0]    pos_z,
  input  logic [31:0]    vel_x,
  input  logic [31:0]    vel_y,
  input  logic [31:0]    vel_z,
  output ppba_pkg::job_t job
);
  import ppba_pkg::*;

  logic [CoordW-1:0] pn;
  logic [CoordW-1:0] vn;
  logic [CoordW:0]   num;
  logic              wall_ok;
  logic              sign_ok;

  always_comb begin
    unique case (cfg.normal_axis)
      AXIS_X: begin pn = pos_x; vn = vel_x; wall_ok = 1'b1; end
      AXIS_Y: begin pn = pos_y; vn = vel_y; wall_ok = 1'b1; end
      AXIS_Z: begin pn = pos_z; vn = vel_z; wall_ok = 1'b1; end
      default: begin pn = pos_x; vn = vel_x; wall_ok = 1'b0; end
    endcase
  end

  assign num = {cfg.plane_offset[CoordW-1], cfg.plane_offset} - {pn[CoordW-1], pn};
  assign sign_ok = (num != '0) && (vn != '0) && (num[CoordW] == vn[CoordW-1]);

  always_comb begin
    job.pos     = {pos_z, pos_y, pos_x};
    job.vel     = {vel_z, vel_y, vel_x};
    job.axis    = cfg.normal_axis;
    job.cand    = wall_ok && sign_ok;
    job.num_mag = num[CoordW] ? CoordW'(-num) : num[CoordW-1:0];
    job.vel_mag = vn[CoordW-1] ? -vn : vn;
  end

endmodule

[sv/ppba_fifo.sv]
// Short queue of classified particles between front and back.
`timescale 1ns / 1ps
module ppba_fifo #(
  parameter int DEPTH = 2
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  ppba_pkg::job_t push_data,
  input  logic           pop,
  output ppba_pkg::job_t pop_data,
  output logic           full,
  output logic           empty
);
  import ppba_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  job_t          mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full     = (count == CW'(DEPTH));
  assign empty    = (count == '0);
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[sv/ppba_back.sv]
// Back: crossing time divider, shared multiplier, reflection and saturation.
`timescale 1ns / 1ps
module ppba_back (
  input  logic           clk,
  input  logic           rst,
  input  ppba_pkg::cfg_t cfg,
  input  ppba_pkg::job_t job,
  input  logic           job_avail,
  output logic           job_pop,
  ppba_out_if.source     out_ch
);
  import ppba_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV  = 3'd1;
  localparam logic [2:0] S_CHK  = 3'd2;
  localparam logic [2:0] S_MULA = 3'd3;
  localparam logic [2:0] S_HIT  = 3'd4;
  localparam logic [2:0] S_MULB = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  localparam logic signed [PosW-1:0] PosMax = PosW'(64'sd2147483647);
  localparam logic signed [PosW-1:0] PosMin = -PosW'(64'sd2147483648);

  logic [2:0]              state;
  logic [5:0]              cnt;
  logic [1:0]              k;
  logic [2:0][PosW-1:0]    p;
  logic [2:0][PosW-1:0]    q;
  logic [2:0][DeltaW-1:0]  d;
  logic [2:0][CoordW-1:0]  vr;
  logic [1:0]              axis;
  logic                    cand;
  logic                    hit;
  logic [CoordW-1:0]       vel_mag;
  logic [CoordW-1:0]       rem;
  logic [QuotW-1:0]        dvd;
  logic [HalfW-1:0]        tval;
  logic [HalfW-1:0]        mul_t;
  logic signed [63:0]      prod;

  logic [CoordW:0]         rsh;
  logic                    qbit;
  logic signed [DeltaW-1:0] prod_q;
  logic signed [PosW-1:0]  cu;
  logic signed [PosW-1:0]  cv;
  logic [PosW-1:0]         cu_abs;
  logic [PosW-1:0]         cv_abs;
  logic                    hit_now;
  logic [2:0]              sat_vec;
  logic [2:0][CoordW-1:0]  q_sat;

  assign rsh     = {rem, dvd[QuotW-1]};
  assign qbit    = (rsh >= {1'b0, vel_mag});
  assign prod_q  = prod[63:FracW];
  assign job_pop = (state == S_IDLE) && job_avail;

  always_comb begin
    priority case (axis)
      AXIS_Y: begin
        cu = $signed(p[0]) + PosW'($signed(d[0])) - PosW'($signed(cfg.center_u));
        cv = $signed(p[2]) + PosW'($signed(d[2])) - PosW'($signed(cfg.center_v));
      end
      AXIS_Z: begin
        cu = $signed(p[0]) + PosW'($signed(d[0])) - PosW'($signed(cfg.center_u));
        cv = $signed(p[1]) + PosW'($signed(d[1])) - PosW'($signed(cfg.center_v));
      end
      default: begin
        cu = $signed(p[1]) + PosW'($signed(d[1])) - PosW'($signed(cfg.center_u));
        cv = $signed(p[2]) + PosW'($signed(d[2])) - PosW'($signed(cfg.center_v));
      end
    endcase
    cu_abs  = cu[PosW-1] ? -cu : cu;
    cv_abs  = cv[PosW-1] ? -cv : cv;
    hit_now = cand && (cu_abs < PosW'(cfg.half_range_u)) && (cv_abs < PosW'(cfg.half_range_v));
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if ($signed(q[i]) > PosMax) begin
        q_sat[i]   = PosMax[CoordW-1:0];
        sat_vec[i] = 1'b1;
      end else if ($signed(q[i]) < PosMin) begin
        q_sat[i]   = PosMin[CoordW-1:0];
        sat_vec[i] = 1'b1;
      end else begin
        q_sat[i]   = q[i][CoordW-1:0];
        sat_vec[i] = 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (job_avail) begin
          for (int i = 0; i < 3; i++) begin
            p[i] <= PosW'($signed(job.pos[i]));
          end
          vr      <= job.vel;
          axis    <= job.axis;
          cand    <= job.cand;
          vel_mag <= job.vel_mag;
          rem     <= '0;
          dvd     <= {job.num_mag, {FracW{1'b0}}};
          tval    <= '0;
          mul_t   <= '0;
          hit     <= 1'b0;
        end
      end
      S_DIV: begin
        rem <= qbit ? CoordW'(rsh - {1'b0, vel_mag}) : rsh[CoordW-1:0];
        dvd <= {dvd[QuotW-2:0], qbit};
      end
      S_CHK: begin
        if ((dvd != '0) && (dvd < QuotW'(cfg.time_step))) begin
          tval  <= dvd[HalfW-1:0];
          mul_t <= dvd[HalfW-1:0];
        end else begin
          cand <= 1'b0;
        end
      end
      S_MULA: begin
        if (k != 2'd3) begin
          prod <= $signed({1'b0, mul_t}) * $signed(vr[0]);
          vr   <= {vr[0], vr[2:1]};
        end
        if (k != 2'd0) begin
          d <= {prod_q, d[2:1]};
        end
      end
      S_HIT: begin
        hit <= hit_now;
        if (hit_now) begin
          for (int i = 0; i < 3; i++) begin
            p[i] <= $signed(p[i]) + PosW'($signed(d[i]));
            if (axis == 2'(i)) begin
              vr[i] <= (vr[i] == {1'b1, {(CoordW-1){1'b0}}}) ? {1'b0, {(CoordW-1){1'b1}}}
                                                             : -vr[i];
            end
          end
          mul_t <= cfg.time_step - tval;
        end else begin
          mul_t <= cfg.time_step;
        end
      end
      S_MULB: begin
        if (k != 2'd3) begin
          prod <= $signed({1'b0, mul_t}) * $signed(vr[0]);
          vr   <= {vr[0], vr[2:1]};
        end
        if (k != 2'd0) begin
          q <= {PosW'($signed(p[0]) + PosW'(prod_q)), q[2:1]};
          p <= {p[0], p[2:1]};
        end
      end
      default: begin
      end
    endcase
  end

  // sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      cnt          <= '0;
      k            <= '0;
      out_ch.valid <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready && (state != S_OUT)) begin
        out_ch.valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          k   <= '0;
          cnt <= 6'(QuotW - 1);
          if (job_avail) begin
            state <= job.cand ? S_DIV : S_MULA;
          end
        end
        S_DIV: begin
          cnt <= cnt - 1'b1;
          if (cnt == '0) begin
            state <= S_CHK;
          end
        end
        S_CHK: begin
          state <= S_MULA;
        end
        S_MULA: begin
          k <= k + 1'b1;
          if (k == 2'd3) begin
            state <= S_HIT;
          end
        end
        S_HIT: begin
          state <= S_MULB;
        end
        S_MULB: begin
          k <= k + 1'b1;
          if (k == 2'd3) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_ch.valid || out_ch.ready) begin
            out_ch.valid <= 1'b1;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_OUT) && (!out_ch.valid || out_ch.ready)) begin
      out_ch.new_pos_x <= q_sat[0];
      out_ch.new_pos_y <= q_sat[1];
      out_ch.new_pos_z <= q_sat[2];
      out_ch.new_vel_x <= vr[0];
      out_ch.new_vel_y <= vr[1];
      out_ch.new_vel_z <= vr[2];
      out_ch.wall_hit  <= hit;
      out_ch.saturated <= |sat_vec;
    end
  end

  a_hit_needs_cand: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT) |-> (!hit || cand)) else $error("hit without crossing candidate");
  a_div_exit: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |=> (state == S_DIV || state == S_CHK)) else $error("divider left early");
  a_div_len: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV && cnt != '0) |=> (state == S_DIV)) else $error("divider cut short");
  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    job_pop |=> (state != S_IDLE)) else $error("job popped without starting");

endmodule
